// ===== hw/rtl/uart_trx_pkg.sv =====
package uart_trx_pkg;

  // Timer width equals the width of the bit period register.
  localparam int TIMER_WIDTH = 16;
  localparam int DATA_BITS   = 8;
  localparam int BYTE_WIDTH  = 8;

  localparam int TX_IDX_WIDTH = $clog2(DATA_BITS + 4);
  localparam int RX_IDX_WIDTH = $clog2(DATA_BITS + 1);

  localparam int IN_WIDTH  = 16;
  localparam int OUT_WIDTH = 16;

  localparam logic [TIMER_WIDTH-1:0] BIT_PERIOD_RESET = TIMER_WIDTH'(104);

  typedef enum logic [0:0] {
    REG_BIT_PERIOD    = 1'b0,
    REG_PARITY_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RX_IDLE      = 2'd0,
    RX_HALF_BIT  = 2'd1,
    RX_SAMPLE    = 2'd2,
    RX_WAIT_HIGH = 2'd3
  } rx_phase_t;

  typedef struct packed {
    logic                  rx_parity_error;
    logic [BYTE_WIDTH-1:0] rx_byte;
    logic                  rx_valid;
    logic                  tx_busy;
    logic                  tx_line;
  } result_t;

endpackage

// ===== hw/rtl/uart_transceiver_with_parity.sv =====
// UART transceiver, 8 data bits, optional even parity, one stop bit.
//
// Every word on the in_ channel is one bit-clock tick: it carries the sampled
// receive line and an optional send request with its byte. Every accepted
// word yields exactly one word on the out_ channel with the transmit line
// level, the busy flag and the receiver status for that tick.
// Transmit frame: start (low), data LSB first, even parity when enabled,
// stop (high); each bit lasts bit_period ticks. A request while busy is
// dropped. The receiver finds the bit middle half a period after the first
// low sample, samples once per period, and reports either rx_valid with the
// byte or rx_parity_error for one tick.
// Each result shows in the cycle after its input word; all tick logic is one
// register stage (state and result), one word per cycle unless out_ stalls.
// The output register holds a result while out_tready is low; in_tready
// stays high as long as that register is empty or being drained, so a stall
// on the out_ side stalls the in_ side with no word lost.
// Reset (rst_n low, synchronous): both sides idle, bit_period 104, parity
// off, output empty. Write cfg_ registers only while no tick is pending.
module uart_transceiver_with_parity
  import uart_trx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [0:0]             cfg_addr,
  input  logic [TIMER_WIDTH-1:0] cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] rx_line, [1] send_request, [9:2] send_byte, [15:10] zero
  input  logic [IN_WIDTH-1:0]    in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte,
  // [11] rx_parity_error, [15:12] zero
  output logic [OUT_WIDTH-1:0]   out_tdata
);

  localparam int TW = TIMER_WIDTH;
  localparam int DB = DATA_BITS;

  // configuration
  logic [TW-1:0] bit_period_r;
  logic          parity_en_r;

  // transmitter state
  logic [DB-1:0]           tx_shift_r,  tx_shift_nxt;
  logic [TX_IDX_WIDTH-1:0] tx_idx_r,    tx_idx_nxt;
  logic [TW-1:0]           tx_timer_r,  tx_timer_nxt;
  logic                    tx_parity_r, tx_parity_nxt;
  logic                    tx_active_r, tx_active_nxt;

  // receiver state
  rx_phase_t               rx_phase_r,  rx_phase_nxt;
  logic [DB-1:0]           rx_shift_r,  rx_shift_nxt;
  logic [RX_IDX_WIDTH-1:0] rx_idx_r,    rx_idx_nxt;
  logic [TW-1:0]           rx_timer_r,  rx_timer_nxt;
  logic                    rx_parity_r, rx_parity_nxt;

  logic          out_valid_r;
  result_t       res_r, res_nxt;

  logic                  accept;
  logic                  rx_in, req_in;
  logic [BYTE_WIDTH-1:0] byte_in;
  logic [TW-1:0]         period;
  logic [TX_IDX_WIDTH-1:0] tx_last;
  logic [TW:0]           tx_inc, rx_inc;
  logic                  rx_half_done, rx_bit_done;
  logic [DB-1:0]         rx_shift_in;
  logic [RX_IDX_WIDTH-1:0] rx_idx_in;
  logic                  tx_line;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_WIDTH'(res_r);

  assign rx_in   = in_tdata[0];
  assign req_in  = in_tdata[1];
  assign byte_in = in_tdata[BYTE_WIDTH+1:2];

  assign period  = (bit_period_r == '0) ? TW'(1) : bit_period_r;
  assign tx_last = TX_IDX_WIDTH'(DB + 1) + TX_IDX_WIDTH'(parity_en_r);
  assign tx_inc  = {1'b0, tx_timer_r} + (TW+1)'(1);
  assign rx_inc  = {1'b0, rx_timer_r} + (TW+1)'(1);

  assign rx_half_done = rx_inc >= {2'b00, period[TW-1:1]};
  assign rx_bit_done  = rx_inc >= {1'b0, period};
  assign rx_shift_in  = {rx_in, rx_shift_r[DB-1:1]};
  assign rx_idx_in    = rx_idx_r + RX_IDX_WIDTH'(1);

  // Transmitter: advance the bit timer, then load a new frame when idle.
  always_comb begin
    logic [DB+BYTE_WIDTH-1:0] byte_ext;
    byte_ext      = {{DB{1'b0}}, byte_in};
    tx_active_nxt = tx_active_r;
    tx_idx_nxt    = tx_idx_r;
    tx_timer_nxt  = tx_timer_r;
    tx_shift_nxt  = tx_shift_r;
    tx_parity_nxt = tx_parity_r;
    if (tx_active_r) begin
      if (tx_inc >= {1'b0, period}) begin
        tx_timer_nxt = '0;
        tx_idx_nxt   = tx_idx_r + TX_IDX_WIDTH'(1);
        if (tx_idx_nxt > tx_last) begin
          tx_active_nxt = 1'b0;
          tx_idx_nxt    = '0;
        end
      end else begin
        tx_timer_nxt = tx_inc[TW-1:0];
      end
    end
    if (!tx_active_nxt && req_in) begin
      tx_active_nxt = 1'b1;
      tx_idx_nxt    = '0;
      tx_timer_nxt  = '0;
      tx_shift_nxt  = byte_ext[DB-1:0];
      tx_parity_nxt = ^byte_ext[DB-1:0];
    end
  end

  always_comb begin
    logic [DB-1:0] shifted;
    shifted = tx_shift_nxt >> (tx_idx_nxt - TX_IDX_WIDTH'(1));
    tx_line = 1'b1;
    if (tx_active_nxt) begin
      if (tx_idx_nxt == '0) begin
        tx_line = 1'b0;
      end else if (tx_idx_nxt <= TX_IDX_WIDTH'(DB)) begin
        tx_line = shifted[0];
      end else if (parity_en_r && tx_idx_nxt == TX_IDX_WIDTH'(DB + 1)) begin
        tx_line = tx_parity_nxt;
      end
    end
  end

  // Receiver next phase.
  always_comb begin
    rx_phase_nxt = rx_phase_r;
    case (rx_phase_r)
      RX_IDLE: begin
        if (!rx_in) rx_phase_nxt = RX_HALF_BIT;
      end
      RX_HALF_BIT: begin
        if (rx_half_done) rx_phase_nxt = RX_SAMPLE;
      end
      RX_SAMPLE: begin
        if (rx_bit_done) begin
          if (rx_idx_r >= RX_IDX_WIDTH'(DB)) begin
            rx_phase_nxt = RX_WAIT_HIGH;
          end else if (rx_idx_in >= RX_IDX_WIDTH'(DB) && !parity_en_r) begin
            rx_phase_nxt = RX_WAIT_HIGH;
          end
        end
      end
      RX_WAIT_HIGH: begin
        if (rx_in) rx_phase_nxt = RX_IDLE;
      end
      default: rx_phase_nxt = RX_IDLE;
    endcase
  end

  // Receiver datapath and result.
  always_comb begin
    logic                     rx_valid, rx_perr;
    logic [DB+BYTE_WIDTH-1:0] byte_src;
    rx_valid      = 1'b0;
    rx_perr       = 1'b0;
    byte_src      = '0;
    rx_timer_nxt  = rx_timer_r;
    rx_shift_nxt  = rx_shift_r;
    rx_idx_nxt    = rx_idx_r;
    rx_parity_nxt = rx_parity_r;
    case (rx_phase_r)
      RX_IDLE: begin
        if (!rx_in) begin
          rx_timer_nxt  = '0;
          rx_shift_nxt  = '0;
          rx_idx_nxt    = '0;
          rx_parity_nxt = 1'b0;
        end
      end
      RX_HALF_BIT: begin
        rx_timer_nxt = rx_half_done ? '0 : rx_inc[TW-1:0];
      end
      RX_SAMPLE: begin
        rx_timer_nxt = rx_bit_done ? '0 : rx_inc[TW-1:0];
        if (rx_bit_done) begin
          if (rx_idx_r < RX_IDX_WIDTH'(DB)) begin
            rx_shift_nxt  = rx_shift_in;
            rx_parity_nxt = rx_parity_r ^ rx_in;
            rx_idx_nxt    = rx_idx_in;
            if (rx_idx_in >= RX_IDX_WIDTH'(DB) && !parity_en_r) begin
              rx_valid = 1'b1;
              byte_src = {{BYTE_WIDTH{1'b0}}, rx_shift_in};
            end
          end else if (rx_in == rx_parity_r) begin
            rx_valid = 1'b1;
            byte_src = {{BYTE_WIDTH{1'b0}}, rx_shift_r};
          end else begin
            rx_perr = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_nxt.tx_line         = tx_line;
    res_nxt.tx_busy         = tx_active_nxt;
    res_nxt.rx_valid        = rx_valid;
    res_nxt.rx_byte         = byte_src[BYTE_WIDTH-1:0];
    res_nxt.rx_parity_error = rx_perr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RESET;
      parity_en_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BIT_PERIOD:    bit_period_r <= cfg_wdata;
        REG_PARITY_ENABLE: parity_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r  <= '0;
      tx_idx_r    <= '0;
      tx_timer_r  <= '0;
      tx_parity_r <= 1'b0;
      tx_active_r <= 1'b0;
      rx_phase_r  <= RX_IDLE;
      rx_shift_r  <= '0;
      rx_idx_r    <= '0;
      rx_timer_r  <= '0;
      rx_parity_r <= 1'b0;
    end else if (accept) begin
      tx_shift_r  <= tx_shift_nxt;
      tx_idx_r    <= tx_idx_nxt;
      tx_timer_r  <= tx_timer_nxt;
      tx_parity_r <= tx_parity_nxt;
      tx_active_r <= tx_active_nxt;
      rx_phase_r  <= rx_phase_nxt;
      rx_shift_r  <= rx_shift_nxt;
      rx_idx_r    <= rx_idx_nxt;
      rx_timer_r  <= rx_timer_nxt;
      rx_parity_r <= rx_parity_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

endmodule

// ===== hw/rtl/uart_trx_checker.sv =====
module uart_trx_sva
  import uart_trx_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_wr_en,
  input logic [0:0]             cfg_addr,
  input logic [TIMER_WIDTH-1:0] cfg_wdata,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_WIDTH-1:0]    in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_WIDTH-1:0]   out_tdata
);

  result_t res;
  assign res = result_t'(out_tdata[$bits(result_t)-1:0]);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Every accepted tick shows a result on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  a_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.rx_valid && res.rx_parity_error))
    else $error("rx_valid and rx_parity_error together");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.rx_valid |-> res.rx_byte == '0)
    else $error("rx_byte nonzero without rx_valid");

  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.tx_busy |-> res.tx_line)
    else $error("tx_line low while transmitter idle");

endmodule

bind uart_transceiver_with_parity uart_trx_sva u_uart_trx_sva (.*);
